@@ design/bmp_pkg.sv @@
// ============================================================================
// bmp_pkg
// Shared constants, types and state encodings for the binomial mod prime
// block: modulus, Barrett constant, Fermat exponent and sequencer states.
// ============================================================================
package bmp_pkg;

  // Field widths
  localparam int VAL_W     = 30;
  localparam int IN_W      = 11;
  localparam int MAX_N_DEF = 1024;

  // Modulus and Fermat exponent p-2
  localparam logic [VAL_W-1:0] PRIME   = 30'd1000000007;
  localparam logic [VAL_W-1:0] INV_EXP = PRIME - 30'd2;

  // Barrett reduction: x < p^2 < 2^60, mu = floor(2^60 / p)
  localparam int MUL_W    = 31;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int RED_W    = 32;
  localparam int Q1_SHIFT = VAL_W - 1;
  localparam int Q3_SHIFT = VAL_W + 1;
  localparam logic [MUL_W-1:0] BARRETT_MU = MUL_W'((64'd1 << PROD_W) / 64'(PRIME));

  // Exponent bit walk, highest set bit of p-2 down to bit 0
  localparam int EXP_BIT_W = 5;
  localparam logic [EXP_BIT_W-1:0] EXP_MSB = 5'd29;

  // Command codes
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Top-level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD,
    ST_RD_K,
    ST_RD_MK,
    ST_RD_M,
    ST_DEN,
    ST_SQR,
    ST_MULB,
    ST_FINAL
  } bmp_state_e;

  // Modular multiplier steps
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_PROD,
    MM_QEST,
    MM_SUB,
    MM_FIX1,
    MM_FIX2
  } mm_state_e;

  // Multiplier status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

@@ design/bmp_ram.sv @@
// ============================================================================
// bmp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module bmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bmp_modmul.sv @@
// ============================================================================
// bmp_modmul
// Multi-cycle modular multiplier a*b mod p. One 31x31 multiplier is shared
// by the product, the Barrett quotient estimate and the quotient times p,
// followed by two conditional subtractions.
// ============================================================================
module bmp_modmul import bmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] a_i,
  input  logic [VAL_W-1:0] b_i,
  output logic [VAL_W-1:0] res_o,
  output mm_stat_t         stat_o
);

  mm_state_e          state_q, state_d;
  logic               done_q, done_d;
  logic [VAL_W-1:0]   a_q, a_d, b_q, b_d, res_q, res_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [MUL_W-1:0]   q3_q, q3_d;
  logic [RED_W-1:0]   r_q, r_d;

  logic [MUL_W-1:0]   mul_x, mul_y;
  logic [2*MUL_W-1:0] mul_p;
  logic [RED_W-1:0]   r_fold;

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      MM_PROD: begin
        mul_x = MUL_W'(a_q);
        mul_y = MUL_W'(b_q);
      end
      MM_QEST: begin
        mul_x = prod_q[PROD_W-1:Q1_SHIFT];
        mul_y = BARRETT_MU;
      end
      MM_SUB: begin
        mul_x = q3_q;
        mul_y = MUL_W'(PRIME);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p  = mul_x * mul_y;

  // One conditional subtraction of p
  assign r_fold = (r_q >= RED_W'(PRIME)) ? (r_q - RED_W'(PRIME)) : r_q;

  // Step sequencer
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    prod_d  = prod_q;
    q3_d    = q3_q;
    r_d     = r_q;
    res_d   = res_q;
    case (state_q)
      MM_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          state_d = MM_PROD;
        end
      end
      MM_PROD: begin
        prod_d  = mul_p[PROD_W-1:0];
        state_d = MM_QEST;
      end
      MM_QEST: begin
        q3_d    = mul_p[2*MUL_W-1:Q3_SHIFT];
        state_d = MM_SUB;
      end
      MM_SUB: begin
        // remainder is below 3p, so 32 low bits are exact
        r_d     = prod_q[RED_W-1:0] - mul_p[RED_W-1:0];
        state_d = MM_FIX1;
      end
      MM_FIX1: begin
        r_d     = r_fold;
        state_d = MM_FIX2;
      end
      MM_FIX2: begin
        res_d   = r_fold[VAL_W-1:0];
        done_d  = 1'b1;
        state_d = MM_IDLE;
      end
      default: begin
        state_d = MM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    q3_q   <= q3_d;
    r_q    <= r_d;
    res_q  <= res_d;
  end

  assign res_o       = res_q;
  assign stat_o.busy = (state_q != MM_IDLE);
  assign stat_o.done = done_q;

endmodule

@@ design/binomial_mod_prime.sv @@
// ============================================================================
// binomial_mod_prime
// Binomial coefficients modulo p = 1000000007 from a factorial table.
// ============================================================================
// Usage: a command word (cmd_i, upper_i, lower_i) is taken on a clock edge
// where start_i is high and busy_o is low. Exactly one result word follows,
// shown on value_o / out_of_range_o for one cycle with done_o high; the
// receiver has no way to hold it, so it must take it in that cycle.
// Build (cmd 0) fills n! mod p for n = 1 .. min(lower_i, MAX_N) and answers
// the top factorial. Query (cmd 1) answers C(upper, lower) mod p. The
// inverse of k!(m-k)! comes from square-and-multiply over the 30 bits of
// p-2 (15 ones); a full query takes 47 modular products. Out-of-table m or
// k > m answer straight from idle, with no product. All products run on the
// shared modular multiplier, which holds one 31x31 multiplier used three
// times per product. A new word can be accepted in the cycle its
// predecessor's result is shown. Reset leaves the table holding only 0!;
// entry 0 reads as 1 at all times and the RAM needs no clearing pass.
// ============================================================================
module binomial_mod_prime import bmp_pkg::*; #(
  parameter int MAX_N = MAX_N_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             cmd_i,
  input  logic [IN_W-1:0]  upper_i,
  input  logic [IN_W-1:0]  lower_i,
  output logic             done_o,
  output logic [VAL_W-1:0] value_o,
  output logic             out_of_range_o
);

  localparam int IDX_W = $clog2(MAX_N + 1);

  bmp_state_e             state_q, state_d;
  logic                   done_q, done_d;
  logic [IDX_W-1:0]       limit_q, limit_d;
  logic [IDX_W-1:0]       top_q, top_d;
  logic [IDX_W-1:0]       i_q, i_d;
  logic [IDX_W-1:0]       raddr_q, raddr_d;
  logic                   zero_q;
  logic [IN_W-1:0]        upper_q, upper_d, lower_q, lower_d;
  logic [VAL_W-1:0]       fk_q, fk_d, fm_q, fm_d, base_q, base_d;
  logic [EXP_BIT_W-1:0]   bit_q, bit_d;
  logic [VAL_W-1:0]       value_q, value_d;
  logic                   oor_q, oor_d;

  logic [IDX_W-1:0]       top_sat;
  logic [IDX_W-1:0]       i_next;
  logic [VAL_W-1:0]       ram_rdata, fact_rd;
  logic                   ram_we;

  logic                   mm_start;
  logic [VAL_W-1:0]       mm_a, mm_b, mm_res;
  mm_stat_t               mm_stat;

  // Factorial table
  bmp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_N + 1)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (i_q),
    .wdata_i (mm_res),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  // Shared modular multiplier
  bmp_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .res_o   (mm_res),
    .stat_o  (mm_stat)
  );

  // 0! is never stored; it reads as one
  assign fact_rd = zero_q ? VAL_W'(1) : ram_rdata;

  // Build top index, clipped to the table
  assign top_sat = (32'(lower_i) > 32'(MAX_N)) ? IDX_W'(MAX_N) : IDX_W'(lower_i);
  assign i_next  = IDX_W'(i_q + 1'b1);

  // Sequencer: next state, multiplier requests, table writes
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    limit_d  = limit_q;
    top_d    = top_q;
    i_d      = i_q;
    raddr_d  = raddr_q;
    upper_d  = upper_q;
    lower_d  = lower_q;
    fk_d     = fk_q;
    fm_d     = fm_q;
    base_d   = base_q;
    bit_d    = bit_q;
    value_d  = value_q;
    oor_d    = oor_q;
    mm_start = 1'b0;
    mm_a     = mm_res;
    mm_b     = mm_res;
    ram_we   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          upper_d = upper_i;
          lower_d = lower_i;
          if (cmd_i == CMD_BUILD) begin
            top_d = top_sat;
            if (top_sat == '0) begin
              limit_d = '0;
              value_d = VAL_W'(1);
              oor_d   = 1'b0;
              done_d  = 1'b1;
            end else begin
              i_d      = IDX_W'(1);
              mm_start = 1'b1;
              mm_a     = VAL_W'(1);
              mm_b     = VAL_W'(1);
              state_d  = ST_BUILD;
            end
          end else if (32'(upper_i) > 32'(limit_q)) begin
            value_d = '0;
            oor_d   = 1'b1;
            done_d  = 1'b1;
          end else if (lower_i > upper_i) begin
            value_d = '0;
            oor_d   = 1'b0;
            done_d  = 1'b1;
          end else begin
            raddr_d = IDX_W'(lower_i);
            state_d = ST_RD_K;
          end
        end
      end
      ST_BUILD: begin
        if (mm_stat.done) begin
          ram_we = 1'b1;
          if (i_q == top_q) begin
            limit_d = top_q;
            value_d = mm_res;
            oor_d   = 1'b0;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            i_d      = i_next;
            mm_start = 1'b1;
            mm_a     = mm_res;
            mm_b     = VAL_W'(i_next);
          end
        end
      end
      ST_RD_K: begin
        raddr_d = IDX_W'(upper_q - lower_q);
        state_d = ST_RD_MK;
      end
      ST_RD_MK: begin
        fk_d    = fact_rd;
        raddr_d = IDX_W'(upper_q);
        state_d = ST_RD_M;
      end
      ST_RD_M: begin
        // denominator k! * (m-k)!
        mm_start = 1'b1;
        mm_a     = fk_q;
        mm_b     = fact_rd;
        state_d  = ST_DEN;
      end
      ST_DEN: begin
        if (mm_stat.done) begin
          fm_d     = fact_rd;
          base_d   = mm_res;
          bit_d    = EXP_MSB;
          mm_start = 1'b1;
          mm_a     = VAL_W'(1);
          mm_b     = VAL_W'(1);
          state_d  = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          mm_start = 1'b1;
          if (INV_EXP[bit_q]) begin
            mm_a    = mm_res;
            mm_b    = base_q;
            state_d = ST_MULB;
          end else if (bit_q == '0) begin
            mm_a    = fm_q;
            mm_b    = mm_res;
            state_d = ST_FINAL;
          end else begin
            bit_d   = bit_q - 1'b1;
          end
        end
      end
      ST_MULB: begin
        if (mm_stat.done) begin
          mm_start = 1'b1;
          if (bit_q == '0) begin
            mm_a    = fm_q;
            mm_b    = mm_res;
            state_d = ST_FINAL;
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = ST_SQR;
          end
        end
      end
      ST_FINAL: begin
        if (mm_stat.done) begin
          value_d = mm_res;
          oor_d   = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      limit_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      limit_q <= limit_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    i_q     <= i_d;
    raddr_q <= raddr_d;
    zero_q  <= (raddr_q == '0);
    upper_q <= upper_d;
    lower_q <= lower_d;
    fk_q    <= fk_d;
    fm_q    <= fm_d;
    base_q  <= base_d;
    bit_q   <= bit_d;
    value_q <= value_d;
    oor_q   <= oor_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign value_o        = value_q;
  assign out_of_range_o = oor_q;

  // A result word is only shown once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // An accepted word either starts work or answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted word dropped");

  // The multiplier is never restarted while it still works on a product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_stat.busy)
    else $error("multiplier restarted while busy");

  // Out-of-range answers carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (value_o == '0))
    else $error("out-of-range result with nonzero value");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for binomial_mod_prime. A queue of command words
// (directed corner cases, then random builds and queries) feeds a clocked
// driver; a clocked monitor compares each answer word with a local factorial
// table and Fermat-inverse predictor.
// ============================================================================
module testbench import bmp_pkg::*; ();

  localparam int MAX_N    = MAX_N_DEF;
  localparam int N_RANDOM = 1728;
  localparam int TAIL     = 300;

  typedef struct packed {
    logic            cmd;
    logic [IN_W-1:0] upper;
    logic [IN_W-1:0] lower;
  } command_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             oor;
  } answer_t;

  // DUT signals; the inputs are known from time zero
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             cmd_i = CMD_BUILD;
  logic [IN_W-1:0]  upper_i = '0;
  logic [IN_W-1:0]  lower_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [VAL_W-1:0] value_o;
  logic             out_of_range_o;

  // Stimulus and scoreboard
  command_t    commands_todo[$];
  answer_t     answers_due[$];
  int unsigned n_total, n_issued, n_checked, n_errors;
  int unsigned n_builds, n_saturated, n_queries, n_oor, n_k_over_m;
  int unsigned n_cycles, cycle_limit;
  int          gen_top;

  // Predictor state: factorials mod p and the current table top
  logic [VAL_W-1:0] fact_tab [0:MAX_N];
  int               tab_top;

  always #6 clk_i = ~clk_i;

  binomial_mod_prime #(
    .MAX_N(MAX_N)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .upper_i        (upper_i),
    .lower_i        (lower_i),
    .done_o         (done_o),
    .value_o        (value_o),
    .out_of_range_o (out_of_range_o)
  );

  function automatic logic [VAL_W-1:0] mulmod(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return VAL_W'(prod % 64'(PRIME));
  endfunction

  // x^(p-2) mod p, square-and-multiply from the top bit down
  function automatic logic [VAL_W-1:0] fermat_inverse(logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] acc;
    acc = VAL_W'(1);
    for (int b = VAL_W - 1; b >= 0; b--) begin
      acc = mulmod(acc, acc);
      if (INV_EXP[b]) acc = mulmod(acc, x);
    end
    return acc;
  endfunction

  // Applies one accepted word to the local table and returns its answer
  function automatic answer_t eval_command(logic cmd, logic [IN_W-1:0] m, logic [IN_W-1:0] k);
    answer_t ans;
    int      top;
    ans = '0;
    if (cmd == CMD_BUILD) begin
      n_builds++;
      top = (int'(k) > MAX_N) ? MAX_N : int'(k);
      if (int'(k) > MAX_N) n_saturated++;
      fact_tab[0] = VAL_W'(1);
      for (int i = 1; i <= top; i++) fact_tab[i] = mulmod(fact_tab[i-1], VAL_W'(i));
      tab_top   = top;
      ans.value = fact_tab[top];
    end else begin
      n_queries++;
      if (int'(m) > tab_top) begin
        // table check wins even when k > m
        n_oor++;
        ans.oor = 1'b1;
      end else if (k > m) begin
        n_k_over_m++;
      end else begin
        ans.value = mulmod(fact_tab[m],
                           fermat_inverse(mulmod(fact_tab[k], fact_tab[m - k])));
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Queues one word and adds its worst-case cycles to the run limit
  task automatic queue_command(input logic cmd, input int m, input int k);
    command_t c;
    int       top;
    c.cmd   = cmd;
    c.upper = IN_W'(m);
    c.lower = IN_W'(k);
    commands_todo.insert(commands_todo.size(), c);
    n_total++;
    if (cmd == CMD_BUILD) begin
      top         = (k > MAX_N) ? MAX_N : k;
      gen_top     = top;
      cycle_limit += 6 * top + 2 + 60;
    end else begin
      cycle_limit += 288 + 60;
    end
  endtask

  // Sender idle share per third of the run: light, heavy, none
  function automatic int unsigned idle_pct();
    if (n_issued < n_total / 3) return 17;
    if (n_issued < 2 * n_total / 3) return 87;
    return 0;
  endfunction

  // Driver: takes a word when start/busy say it went in, then presents the next
  always @(posedge clk_i or negedge rst_ni) begin : driver
    command_t nxt;
    logic     may_load;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cmd_i   <= CMD_BUILD;
      upper_i <= '0;
      lower_i <= '0;
    end else begin
      may_load = !start_i;
      if (start_i && !busy_o) begin
        answers_due.insert(answers_due.size(), eval_command(cmd_i, upper_i, lower_i));
        may_load = 1'b1;
      end
      if (may_load) begin
        if (commands_todo.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          nxt = commands_todo.pop_front();
          n_issued++;
          cmd_i   <= nxt.cmd;
          upper_i <= nxt.upper;
          lower_i <= nxt.lower;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed answer word against the oldest prediction
  always @(posedge clk_i) begin : monitor
    answer_t want;
    if (rst_ni && done_o) begin
      n_checked++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("answer %0d arrived with nothing due", n_checked));
      end else begin
        want = answers_due.pop_front();
        if (value_o !== want.value)
          report_mismatch($sformatf("answer %0d value %0d, want %0d",
                                    n_checked, value_o, want.value));
        if (out_of_range_o !== want.oor)
          report_mismatch($sformatf("answer %0d out_of_range %b, want %b",
                                    n_checked, out_of_range_o, want.oor));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > cycle_limit) begin
      $display("timeout after %0d cycles, %0d answers still due", n_cycles, answers_due.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int pick, top, m, k;
    fact_tab[0] = VAL_W'(1);
    tab_top     = 0;
    gen_top     = 0;
    cycle_limit = 0;

    // Directed: empty table, full table, saturation, shrink, small table
    queue_command(CMD_QUERY, 0, 0);
    queue_command(CMD_QUERY, 1, 0);
    queue_command(CMD_QUERY, 5, 2047);
    queue_command(CMD_BUILD, 2047, 0);
    queue_command(CMD_BUILD, 0, 1024);
    queue_command(CMD_QUERY, 1024, 0);
    queue_command(CMD_QUERY, 1024, 1024);
    queue_command(CMD_QUERY, 1024, 512);
    queue_command(CMD_QUERY, 1024, 1);
    queue_command(CMD_QUERY, 1023, 2047);
    queue_command(CMD_QUERY, 1025, 3);
    queue_command(CMD_QUERY, 2047, 0);
    queue_command(CMD_BUILD, 1365, 2047);
    queue_command(CMD_QUERY, 1000, 777);
    queue_command(CMD_BUILD, 682, 1535);
    queue_command(CMD_BUILD, 0, 10);
    queue_command(CMD_QUERY, 11, 3);
    queue_command(CMD_QUERY, 10, 5);
    queue_command(CMD_QUERY, 10, 11);
    queue_command(CMD_BUILD, 0, 1);
    queue_command(CMD_QUERY, 1, 1);
    queue_command(CMD_QUERY, 1, 0);

    // Random: mostly well-formed queries against the current table
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        pick = $urandom_range(99);
        if (pick < 80)      top = $urandom_range(150, 0);
        else if (pick < 95) top = $urandom_range(1024, 151);
        else                top = $urandom_range(2047, 1025);
        queue_command(CMD_BUILD, $urandom_range(2047, 0), top);
      end else begin
        pick = $urandom_range(99);
        m    = $urandom_range(gen_top, 0);
        if (pick < 78) begin
          k = $urandom_range(m, 0);
        end else if (pick < 86) begin
          k = $urandom_range(2047, m + 1);
        end else if (pick < 96) begin
          m = $urandom_range(2047, gen_top + 1);
          k = $urandom_range(2047, 0);
        end else begin
          k = $urandom_range(1) ? m : 0;
        end
        queue_command(CMD_QUERY, m, k);
      end
    end
    cycle_limit = 4 * cycle_limit + 20000;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words in, all answers back, then a quiet tail
    while (commands_todo.size() != 0 || start_i) @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    while (answers_due.size() != 0) begin
      void'(answers_due.pop_front());
      report_mismatch("predicted answer never arrived");
    end

    $display("covered %0d builds (%0d saturated) and %0d queries (%0d off table, %0d k>m)",
             n_builds, n_saturated, n_queries, n_oor, n_k_over_m);
    $display("%0d answers checked in %0d cycles, %0d mismatches",
             n_checked, n_cycles, n_errors);
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
